// ----- design/spi_flash_program_erase_sequencer_assert.svh -----
// Assertion macros shared by the sequencer's checker.
`ifndef SPI_FLASH_PROGRAM_ERASE_SEQUENCER_ASSERT_SVH
`define SPI_FLASH_PROGRAM_ERASE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SFPE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SFPE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sfpe_pkg.sv -----
// Shared types and constants of the SPI flash program and erase sequencer.
package sfpe_pkg;

	// Page size in bytes; must be a power of two.
	localparam int PAGE_BYTES = 256;
	localparam int PAGE_AW    = $clog2(PAGE_BYTES);
	localparam int CHUNK_W    = $clog2(PAGE_BYTES + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam int STEP_W = 3;

	localparam logic [1:0] FUNC_PROG_REQ  = 2'd0;
	localparam logic [1:0] FUNC_PROG_DATA = 2'd1;
	localparam logic [1:0] FUNC_ERASE_REQ = 2'd2;
	localparam logic [1:0] FUNC_STATUS    = 2'd3;

	localparam logic [1:0] K_SPI    = 2'd0;
	localparam logic [1:0] K_DONE   = 2'd1;
	localparam logic [1:0] K_REJECT = 2'd2;

	localparam logic [7:0] CMD_RDSR  = 8'h05;
	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] CMD_PP    = 8'h02;
	localparam logic [7:0] CMD_SE    = 8'h20;
	localparam logic [7:0] DUMMY     = 8'hFF;
	localparam logic [7:0] BUSY_MASK = 8'h01;

	// Burst of results that one accepted input produces.
	typedef enum logic [2:0] {
		SEQ_DONE,
		SEQ_REJECT,
		SEQ_POLL,
		SEQ_DATA,
		SEQ_DATA_END,
		SEQ_PROG,
		SEQ_ERASE
	} seq_t;

	typedef struct packed {
		seq_t        seq;
		logic [7:0]  data;
		logic [23:0] addr;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} push_ctl_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} pop_ctl_t;

endpackage

// ----- design/spi_flash_program_erase_sequencer.sv -----
// Throughput: an input is taken every cycle while the four-entry command queue has room.
// Each input yields one to seven results; the back end emits one result per cycle unless out_ready
// stalls the output. An accepted input is written into the command queue; its first result is then
// loaded from the queue head into the output registers.
// Reset: arst_n clears the phase, the operation registers, the queue and the output valid.
// SPI NOR flash program and erase sequencer, top level.
module spi_flash_program_erase_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [23:0] address,
	input  logic [23:0] length,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  spi_byte,
	output logic        cs_release,
	output logic        read_reply,
	output logic        last
);
	import sfpe_pkg::*;

	push_ctl_t push_ctl;
	pop_ctl_t  pop_stat;
	cmd_t      push_cmd;
	cmd_t      head;
	logic      q_full;
	logic      q_pop;

	sfpe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.address  (address),
		.length   (length),
		.data     (data),
		.q_push   (push_ctl),
		.q_full   (q_full),
		.q_cmd    (push_cmd)
	);

	sfpe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_ctl (push_ctl),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_stat (pop_stat),
		.head     (head)
	);

	sfpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (pop_stat),
		.head       (head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.spi_byte   (spi_byte),
		.cs_release (cs_release),
		.read_reply (read_reply),
		.last       (last)
	);

endmodule

// ----- design/sfpe_front.sv -----
// Front end: tracks the operation phase and turns each input transaction into a burst command.
module sfpe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [23:0]        address,
	input  logic [23:0]        length,
	input  logic [7:0]         data,
	output sfpe_pkg::push_ctl_t q_push,
	input  logic               q_full,
	output sfpe_pkg::cmd_t     q_cmd
);
	import sfpe_pkg::*;

	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_POLL_PRE  = 2'd1;
	localparam logic [1:0] PH_DATA      = 2'd2;
	localparam logic [1:0] PH_POLL_POST = 2'd3;

	logic [1:0]         phase_q, phase_d;
	logic               erase_q, erase_d;
	logic [23:0]        cursor_q, cursor_d;
	logic [23:0]        left_q, left_d;
	logic [CHUNK_W-1:0] chunk_q, chunk_d;

	logic               accept;
	logic [23:0]        ld_addr;
	logic [23:0]        ld_left;
	logic [CHUNK_W-1:0] room;
	logic [CHUNK_W-1:0] ld_chunk;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// A new chunk ends at the next page boundary or at the end of the request.
	assign ld_addr  = (phase_q == PH_IDLE) ? address : cursor_q;
	assign ld_left  = (phase_q == PH_IDLE) ? length : left_q;
	assign room     = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(ld_addr[PAGE_AW-1:0]);
	assign ld_chunk = (ld_left < 24'(room)) ? ld_left[CHUNK_W-1:0] : room;

	always_comb begin
		phase_d  = phase_q;
		erase_d  = erase_q;
		cursor_d = cursor_q;
		left_d   = left_q;
		chunk_d  = chunk_q;
		q_cmd.seq  = SEQ_REJECT;
		q_cmd.data = data;
		q_cmd.addr = cursor_q;
		if (func == FUNC_PROG_REQ && phase_q == PH_IDLE) begin
			if (length == 24'd0) begin
				q_cmd.seq = SEQ_DONE;
			end else begin
				erase_d   = 1'b0;
				cursor_d  = address;
				left_d    = length;
				chunk_d   = ld_chunk;
				phase_d   = PH_POLL_PRE;
				q_cmd.seq = SEQ_POLL;
			end
		end else if (func == FUNC_ERASE_REQ && phase_q == PH_IDLE) begin
			erase_d   = 1'b1;
			cursor_d  = address;
			left_d    = 24'd0;
			chunk_d   = '0;
			phase_d   = PH_POLL_PRE;
			q_cmd.seq = SEQ_POLL;
		end else if (func == FUNC_PROG_DATA && phase_q == PH_DATA && chunk_q != '0) begin
			chunk_d  = chunk_q - CHUNK_W'(1);
			left_d   = left_q - 24'd1;
			cursor_d = cursor_q + 24'd1;
			if (chunk_q == CHUNK_W'(1)) begin
				q_cmd.seq = SEQ_DATA_END;
				phase_d   = PH_POLL_POST;
			end else begin
				q_cmd.seq = SEQ_DATA;
			end
		end else if (func == FUNC_STATUS
				&& (phase_q == PH_POLL_PRE || phase_q == PH_POLL_POST)) begin
			if ((data & BUSY_MASK) != 8'd0) begin
				q_cmd.seq = SEQ_POLL;
			end else if (phase_q == PH_POLL_PRE) begin
				if (erase_q) begin
					q_cmd.seq = SEQ_ERASE;
					phase_d   = PH_POLL_POST;
				end else begin
					q_cmd.seq = SEQ_PROG;
					phase_d   = PH_DATA;
				end
			end else if (erase_q || left_q == 24'd0) begin
				q_cmd.seq = SEQ_DONE;
				phase_d   = PH_IDLE;
			end else begin
				chunk_d   = ld_chunk;
				q_cmd.seq = SEQ_POLL;
				phase_d   = PH_POLL_PRE;
			end
		end
	end

	assign q_push.push = accept;
	assign q_push.full = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			erase_q  <= 1'b0;
			cursor_q <= '0;
			left_q   <= '0;
			chunk_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			erase_q  <= erase_d;
			cursor_q <= cursor_d;
			left_q   <= left_d;
			chunk_q  <= chunk_d;
		end
	end

endmodule

// ----- design/sfpe_queue.sv -----
// Short command queue between the front end and the byte expander.
module sfpe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  sfpe_pkg::push_ctl_t push_ctl,
	input  sfpe_pkg::cmd_t      push_cmd,
	output logic                full,
	input  logic                pop,
	output sfpe_pkg::pop_ctl_t  pop_stat,
	output sfpe_pkg::cmd_t      head
);
	import sfpe_pkg::*;

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push;
	logic                do_pop;
	logic                empty;

	assign full    = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push_ctl.push && !push_ctl.full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	assign pop_stat.pop   = do_pop;
	assign pop_stat.empty = empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

// ----- design/sfpe_back.sv -----
// Back end: expands queued commands into results, one per cycle unless stalled.
module sfpe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sfpe_pkg::pop_ctl_t q_stat,
	input  sfpe_pkg::cmd_t     head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [7:0]         spi_byte,
	output logic               cs_release,
	output logic               read_reply,
	output logic               last
);
	import sfpe_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        byte_q;
	logic              cs_q;
	logic              rr_q;
	logic              last_q;

	logic [1:0] r_kind;
	logic [7:0] r_byte;
	logic       r_cs;
	logic       r_rr;
	logic       r_last;
	logic       load;

	assign load  = !q_stat.empty && (!out_valid_q || out_ready);
	assign q_pop = load && r_last;

	// Result for the current step of the head command.
	always_comb begin
		r_kind = K_SPI;
		r_byte = 8'd0;
		r_cs   = 1'b0;
		r_rr   = 1'b0;
		r_last = 1'b0;
		unique case (head.seq) inside
			SEQ_DONE: begin
				r_kind = K_DONE;
				r_last = 1'b1;
			end
			SEQ_REJECT: begin
				r_kind = K_REJECT;
				r_last = 1'b1;
			end
			SEQ_POLL: begin
				if (step_q == STEP_W'(0)) begin
					r_byte = CMD_RDSR;
				end else begin
					r_byte = DUMMY;
					r_cs   = 1'b1;
					r_rr   = 1'b1;
					r_last = 1'b1;
				end
			end
			SEQ_DATA: begin
				r_byte = head.data;
				r_last = 1'b1;
			end
			SEQ_DATA_END: begin
				if (step_q == STEP_W'(0)) begin
					r_byte = head.data;
					r_cs   = 1'b1;
				end else if (step_q == STEP_W'(1)) begin
					r_byte = CMD_RDSR;
				end else begin
					r_byte = DUMMY;
					r_cs   = 1'b1;
					r_rr   = 1'b1;
					r_last = 1'b1;
				end
			end
			SEQ_PROG, SEQ_ERASE: begin
				case (step_q)
					STEP_W'(0): begin
						r_byte = CMD_WREN;
						r_cs   = 1'b1;
					end
					STEP_W'(1): r_byte = (head.seq == SEQ_ERASE) ? CMD_SE : CMD_PP;
					STEP_W'(2): r_byte = head.addr[23:16];
					STEP_W'(3): r_byte = head.addr[15:8];
					STEP_W'(4): begin
						r_byte = head.addr[7:0];
						r_cs   = (head.seq == SEQ_ERASE);
						r_last = (head.seq == SEQ_PROG);
					end
					STEP_W'(5): r_byte = CMD_RDSR;
					default: begin
						r_byte = DUMMY;
						r_cs   = 1'b1;
						r_rr   = 1'b1;
						r_last = 1'b1;
					end
				endcase
			end
			default: begin
				r_kind = K_REJECT;
				r_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= r_last ? '0 : step_q + STEP_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= r_kind;
			byte_q <= r_byte;
			cs_q   <= r_cs;
			rr_q   <= r_rr;
			last_q <= r_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign spi_byte   = byte_q;
	assign cs_release = cs_q;
	assign read_reply = rr_q;
	assign last       = last_q;

endmodule

// ----- design/sfpe_checker.sv -----
// Port-level checker for the sequencer and its bind to the top level.
`include "spi_flash_program_erase_sequencer_assert.svh"

module sfpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  spi_byte,
	input logic        cs_release,
	input logic        read_reply,
	input logic        last
);
	import sfpe_pkg::*;

	// Completion and rejection carry no SPI byte and always close their transaction.
	`SFPE_ASSERT_IMP(a_non_spi_clean, out_valid && kind != K_SPI,
		spi_byte == 8'd0 && !cs_release && !read_reply && last,
		"non-SPI result carries SPI fields")

	// A status read is always the dummy byte that ends a poll.
	`SFPE_ASSERT_IMP(a_reply_is_poll, out_valid && read_reply,
		kind == K_SPI && cs_release && spi_byte == DUMMY,
		"status reply is not a closing dummy byte")

	// A byte that drops chip select without a status read is always followed by more bytes.
	`SFPE_ASSERT_IMP(a_release_open, out_valid && kind == K_SPI && cs_release && !read_reply,
		!last,
		"chip select release without status ends the burst")

	// A result that waits holds its payload.
	`SFPE_ASSERT_NXT(a_hold, out_valid && !out_ready,
		out_valid && $stable(kind) && $stable(spi_byte) && $stable(cs_release) && $stable(last),
		"stalled result changed")

endmodule

bind spi_flash_program_erase_sequencer sfpe_checker u_sfpe_checker (.*);
